/* design/rmq_pkg.sv */
// ----------------------------------------------------------------------------
// rmq_pkg
// Shared types and widths for the rotation matrix to quaternion block.
// ----------------------------------------------------------------------------
package rmq_pkg;

  // raw vector magnitude, sized for the widest fraction setting
  localparam int MAG_W  = 32;
  // normalized magnitude, leading one at bit 29
  localparam int NMAG_W = 30;
  localparam int SQ_W   = 2 * NMAG_W;
  localparam int SUM_W  = SQ_W + 2;
  localparam int ROOT_W = SUM_W / 2;
  localparam int SREM_W = ROOT_W + 4;
  localparam int DREM_W = ROOT_W + 1;

  // classified item handed from front to back
  typedef struct packed {
    logic                  degen;
    logic [3:0]            neg;
    logic [3:0][MAG_W-1:0] mag;
  } rmq_item_t;

endpackage

/* design/rmq_front.sv */
// ----------------------------------------------------------------------------
// rmq_front
// Accept a matrix, pick the branch and build the unnormalized vector.
// ----------------------------------------------------------------------------
module rmq_front import rmq_pkg::*; #(
  parameter int FRAC_BITS = 14
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] m00,
  input  logic signed [15:0] m01,
  input  logic signed [15:0] m02,
  input  logic signed [15:0] m10,
  input  logic signed [15:0] m11,
  input  logic signed [15:0] m12,
  input  logic signed [15:0] m20,
  input  logic signed [15:0] m21,
  input  logic signed [15:0] m22,
  output logic               out_valid,
  output rmq_item_t          out_item,
  input  logic               out_ready
);

  localparam logic signed [33:0] ONE = 34'sd1 <<< FRAC_BITS;

  logic signed [33:0] e00, e01, e02, e10, e11, e12, e20, e21, e22;
  logic signed [33:0] t, u;
  logic signed [43:0] t1000;
  logic signed [33:0] v [4];
  logic [1:0]         k;
  logic               dg, trace_br, accept;
  rmq_item_t          item_next;

  assign busy   = out_valid & ~out_ready;
  assign accept = start & ~busy;

  assign e00 = 34'(m00);
  assign e01 = 34'(m01);
  assign e02 = 34'(m02);
  assign e10 = 34'(m10);
  assign e11 = 34'(m11);
  assign e12 = 34'(m12);
  assign e20 = 34'(m20);
  assign e21 = 34'(m21);
  assign e22 = 34'(m22);

  // trace test
  assign t        = ONE + e00 + e11 + e22;
  assign t1000    = 44'(t) * 44'sd1000;
  assign trace_br = (t > 34'sd0) && (t1000 > 44'(ONE));

  // branch selection and radicand clamp
  always_comb begin
    for (int i = 0; i < 4; i++) v[i] = '0;
    u  = '0;
    k  = 2'd0;
    dg = 1'b0;
    if (trace_br) begin
      v[0] = e21 - e12;
      v[1] = e02 - e20;
      v[2] = e10 - e01;
      v[3] = t;
    end else begin
      if (e00 > e11 && e00 > e22) begin
        u = ONE + e00 - e11 - e22;
        k = 2'd0;
        v[1] = e01 + e10;
        v[2] = e02 + e20;
        v[3] = e21 - e12;
      end else if (e11 > e22) begin
        u = ONE + e11 - e00 - e22;
        k = 2'd1;
        v[0] = e01 + e10;
        v[2] = e12 + e21;
        v[3] = e02 - e20;
      end else begin
        u = ONE + e22 - e00 - e11;
        k = 2'd2;
        v[0] = e02 + e20;
        v[1] = e12 + e21;
        v[3] = e10 - e01;
      end
      if (u <= 34'sd0) begin
        u  = 34'sd1;
        dg = 1'b1;
      end
      v[k] = u;
    end
  end

  // split into sign and magnitude
  always_comb begin
    item_next.degen = dg;
    for (int i = 0; i < 4; i++) begin
      item_next.neg[i] = v[i] < 34'sd0;
      item_next.mag[i] = MAG_W'(v[i] < 34'sd0 ? -v[i] : v[i]);
    end
  end

  // hold the beat until the queue takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= accept | (out_valid & ~out_ready);
    end
    if (accept) begin
      out_item <= item_next;
    end
  end

endmodule

/* design/rmq_queue.sv */
// ----------------------------------------------------------------------------
// rmq_queue
// Two-entry queue between the front and the back.
// ----------------------------------------------------------------------------
module rmq_queue import rmq_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  rmq_item_t in_item,
  output logic      in_ready,
  output logic      out_valid,
  output rmq_item_t out_item
);

  rmq_item_t  mem [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;
  logic       push, pop;

  assign in_ready  = count != 2'd2;
  assign out_valid = count != 2'd0;
  assign out_item  = mem[rd_ptr];
  assign push      = in_valid & in_ready;
  // the back never stalls: drain every cycle
  assign pop       = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
    if (push) begin
      mem[wr_ptr] <= in_item;
    end
  end

endmodule

/* design/rmq_back.sv */
// ----------------------------------------------------------------------------
// rmq_back
// Normalize, square root and divide, one item per cycle through a pipeline.
// ----------------------------------------------------------------------------
module rmq_back import rmq_pkg::*; #(
  parameter int FRAC_BITS = 14
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  rmq_item_t          in_item,
  output logic               done,
  output logic signed [15:0] quat_x,
  output logic signed [15:0] quat_y,
  output logic signed [15:0] quat_z,
  output logic signed [15:0] quat_w,
  output logic               degenerate
);

  localparam int QW = FRAC_BITS + 1;
  localparam int NW = NMAG_W + FRAC_BITS + 1;

  // stage A: largest magnitude
  logic                  a_valid;
  rmq_item_t             a_item;
  logic [MAG_W-1:0]      a_max;
  logic [MAG_W-1:0]      mx01, mx23;

  assign mx01 = in_item.mag[0] > in_item.mag[1] ? in_item.mag[0] : in_item.mag[1];
  assign mx23 = in_item.mag[2] > in_item.mag[3] ? in_item.mag[2] : in_item.mag[3];

  always_ff @(posedge clk) begin
    if (rst) a_valid <= 1'b0;
    else     a_valid <= in_valid;
    a_item <= in_item;
    a_max  <= mx01 > mx23 ? mx01 : mx23;
  end

  // stage B: leading one position
  logic       b_valid;
  rmq_item_t  b_item;
  logic [4:0] b_msb;
  logic [4:0] msb_next;

  always_comb begin
    msb_next = 5'd0;
    for (int i = 0; i < MAG_W; i++) begin
      if (a_max[i]) msb_next = 5'(i);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) b_valid <= 1'b0;
    else     b_valid <= a_valid;
    b_item <= a_item;
    b_msb  <= msb_next;
  end

  // stage C: common shift, leading one lands at bit 29
  logic                   c_valid, c_degen;
  logic [3:0]             c_neg;
  logic [3:0][NMAG_W-1:0] c_mag;
  logic [60:0]            sh [4];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      sh[i] = (61'(b_item.mag[i]) << 29) >> b_msb;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) c_valid <= 1'b0;
    else     c_valid <= b_valid;
    c_degen <= b_item.degen;
    c_neg   <= b_item.neg;
    for (int i = 0; i < 4; i++) c_mag[i] <= sh[i][NMAG_W-1:0];
  end

  // stage D: squares
  logic                   d_valid, d_degen;
  logic [3:0]             d_neg;
  logic [3:0][NMAG_W-1:0] d_mag;
  logic [SQ_W-1:0]        d_sq [4];

  always_ff @(posedge clk) begin
    if (rst) d_valid <= 1'b0;
    else     d_valid <= c_valid;
    d_degen <= c_degen;
    d_neg   <= c_neg;
    d_mag   <= c_mag;
    for (int i = 0; i < 4; i++) d_sq[i] <= SQ_W'(c_mag[i]) * SQ_W'(c_mag[i]);
  end

  // sqrt pipeline, one root bit per stage; index 0 is the sum
  logic                   s_valid [ROOT_W+1];
  logic                   s_degen [ROOT_W+1];
  logic [3:0]             s_neg   [ROOT_W+1];
  logic [3:0][NMAG_W-1:0] s_mag   [ROOT_W+1];
  logic [SUM_W-1:0]       s_n     [ROOT_W+1];
  logic [SREM_W-1:0]      s_rem   [ROOT_W+1];
  logic [ROOT_W-1:0]      s_root  [ROOT_W+1];

  always_ff @(posedge clk) begin
    if (rst) s_valid[0] <= 1'b0;
    else     s_valid[0] <= d_valid;
    s_degen[0] <= d_degen;
    s_neg[0]   <= d_neg;
    s_mag[0]   <= d_mag;
    s_n[0]     <= (SUM_W'(d_sq[0]) + SUM_W'(d_sq[1])) + (SUM_W'(d_sq[2]) + SUM_W'(d_sq[3]));
    s_rem[0]   <= '0;
    s_root[0]  <= '0;
  end

  for (genvar k = 0; k < ROOT_W; k++) begin : g_sqrt
    logic [SREM_W-1:0] rem_t, trial;

    assign rem_t = {s_rem[k][SREM_W-3:0], s_n[k][SUM_W-1 -: 2]};
    assign trial = {1'b0, s_root[k], 2'b01};

    // try one root bit
    always_ff @(posedge clk) begin
      if (rst) s_valid[k+1] <= 1'b0;
      else     s_valid[k+1] <= s_valid[k];
      s_degen[k+1] <= s_degen[k];
      s_neg[k+1]   <= s_neg[k];
      s_mag[k+1]   <= s_mag[k];
      s_n[k+1]     <= s_n[k] << 2;
      if (rem_t >= trial) begin
        s_rem[k+1]  <= rem_t - trial;
        s_root[k+1] <= {s_root[k][ROOT_W-2:0], 1'b1};
      end else begin
        s_rem[k+1]  <= rem_t;
        s_root[k+1] <= {s_root[k][ROOT_W-2:0], 1'b0};
      end
    end
  end

  // divide pipeline, one quotient bit per stage; index 0 loads the numerator
  logic              q_valid [QW+1];
  logic              q_degen [QW+1];
  logic [3:0]        q_neg   [QW+1];
  logic [ROOT_W-1:0] q_r     [QW+1];
  logic [DREM_W-1:0] q_rem   [QW+1][4];
  logic [QW-1:0]     q_low   [QW+1][4];
  logic [QW-1:0]     q_quo   [QW+1][4];
  logic [NW-1:0]     numer   [4];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      numer[i] = (NW'(s_mag[ROOT_W][i]) << FRAC_BITS) + NW'(s_root[ROOT_W] >> 1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) q_valid[0] <= 1'b0;
    else     q_valid[0] <= s_valid[ROOT_W];
    q_degen[0] <= s_degen[ROOT_W];
    q_neg[0]   <= s_neg[ROOT_W];
    q_r[0]     <= s_root[ROOT_W];
    for (int i = 0; i < 4; i++) begin
      q_rem[0][i] <= DREM_W'(numer[i] >> QW);
      q_low[0][i] <= numer[i][QW-1:0];
      q_quo[0][i] <= '0;
    end
  end

  for (genvar j = 0; j < QW; j++) begin : g_div
    logic [DREM_W-1:0] rem_t [4];

    always_comb begin
      for (int i = 0; i < 4; i++) begin
        rem_t[i] = {q_rem[j][i][DREM_W-2:0], q_low[j][i][QW-1]};
      end
    end

    // subtract the root where it fits
    always_ff @(posedge clk) begin
      if (rst) q_valid[j+1] <= 1'b0;
      else     q_valid[j+1] <= q_valid[j];
      q_degen[j+1] <= q_degen[j];
      q_neg[j+1]   <= q_neg[j];
      q_r[j+1]     <= q_r[j];
      for (int i = 0; i < 4; i++) begin
        q_low[j+1][i] <= q_low[j][i] << 1;
        if (rem_t[i] >= DREM_W'(q_r[j])) begin
          q_rem[j+1][i] <= rem_t[i] - DREM_W'(q_r[j]);
          q_quo[j+1][i] <= {q_quo[j][i][QW-2:0], 1'b1};
        end else begin
          q_rem[j+1][i] <= rem_t[i];
          q_quo[j+1][i] <= {q_quo[j][i][QW-2:0], 1'b0};
        end
      end
    end
  end

  // saturate and apply sign
  logic [15:0] res [4];
  logic [31:0] qe;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      qe = 32'(q_quo[QW][i]);
      if (q_neg[QW][i]) begin
        if (qe > 32'd32768) qe = 32'd32768;
        res[i] = 16'(32'd0 - qe);
      end else begin
        if (qe > 32'd32767) qe = 32'd32767;
        res[i] = qe[15:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else     done <= q_valid[QW];
    quat_x     <= res[0];
    quat_y     <= res[1];
    quat_z     <= res[2];
    quat_w     <= res[3];
    degenerate <= q_degen[QW];
  end

endmodule

/* design/rotation_matrix_to_quaternion.sv */
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion
// Convert a Q1.14 rotation matrix into a normalized quaternion.
//
//   channel  direction  handshake          payload
//   item     in         start & !busy      m00 .. m22
//   result   out        done (one cycle)   quat_x quat_y quat_z quat_w degenerate
//
// One item per cycle sustained. An accepted item passes the front register,
// the queue, four normalize and square stages, the sum, the 31-stage square
// root, the divider load, the FRAC_BITS + 1 divide stages and the output
// register, which raises done.
// Synchronous reset empties every stage; no clearing pass.
// The receiver cannot stall; busy rises only while the queue is full.
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion import rmq_pkg::*; #(
  parameter int FRAC_BITS = 14
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] m00,
  input  logic signed [15:0] m01,
  input  logic signed [15:0] m02,
  input  logic signed [15:0] m10,
  input  logic signed [15:0] m11,
  input  logic signed [15:0] m12,
  input  logic signed [15:0] m20,
  input  logic signed [15:0] m21,
  input  logic signed [15:0] m22,
  output logic               done,
  output logic signed [15:0] quat_x,
  output logic signed [15:0] quat_y,
  output logic signed [15:0] quat_z,
  output logic signed [15:0] quat_w,
  output logic               degenerate
);

  logic      f_valid, f_ready, b_valid;
  rmq_item_t f_item, b_item;

  rmq_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk, .rst, .start, .busy,
    .m00, .m01, .m02, .m10, .m11, .m12, .m20, .m21, .m22,
    .out_valid(f_valid), .out_item(f_item), .out_ready(f_ready)
  );

  rmq_queue u_queue (
    .clk, .rst,
    .in_valid(f_valid), .in_item(f_item), .in_ready(f_ready),
    .out_valid(b_valid), .out_item(b_item)
  );

  rmq_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk, .rst,
    .in_valid(b_valid), .in_item(b_item),
    .done, .quat_x, .quat_y, .quat_z, .quat_w, .degenerate
  );

endmodule

/* design/rmq_checker.sv */
// ----------------------------------------------------------------------------
// rmq_checker
// Port-level checks for the rotation matrix to quaternion block.
// ----------------------------------------------------------------------------
module rmq_checker (
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input logic               done,
  input logic signed [15:0] quat_x,
  input logic signed [15:0] quat_y,
  input logic signed [15:0] quat_z,
  input logic signed [15:0] quat_w
);

  // reset empties the pipeline
  a_reset: assert property (@(posedge clk) rst |=> !busy && !done)
    else $error("busy or done right after reset");

  // a unit quaternion never comes out all zero
  a_nonzero: assert property (@(posedge clk) disable iff (rst)
    done |-> (quat_x != 16'sd0 || quat_y != 16'sd0 || quat_z != 16'sd0 || quat_w != 16'sd0))
    else $error("zero quaternion delivered");

  // the queue drains every cycle, so a beat never causes backpressure
  a_no_stall: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> !busy)
    else $error("busy after a single beat");

endmodule

bind rotation_matrix_to_quaternion rmq_checker u_rmq_checker (.*);
